// ===== hw/rtl/bus_address_decoder_unit_defines.svh =====
// Assertion macros shared by the bus address decoder RTL.
// Users must have signals named clk and arst_n in scope.
`ifndef BUS_ADDRESS_DECODER_UNIT_DEFINES_SVH
`define BUS_ADDRESS_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BUSDEC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("busdec check failed");

// Next-cycle implication, checked outside reset.
`define BUSDEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("busdec check failed");

`endif

// ===== hw/rtl/busdec_pkg.sv =====
// Types, codes and memory map constants for the bus address decoder.
// No dependencies; used by busdec_decode and bus_address_decoder_unit.
`timescale 1ns / 1ps

package busdec_pkg;

	localparam int unsigned RAM_BYTES_DEF     = 2097152;
	localparam int unsigned BIOS_BYTES_DEF    = 524288;
	localparam int unsigned SCRATCH_BYTES_DEF = 1024;

	localparam int OFFSET_W = 21;

	// Access kinds.
	localparam logic [2:0] KIND_RB = 3'd0;
	localparam logic [2:0] KIND_RH = 3'd1;
	localparam logic [2:0] KIND_RW = 3'd2;
	localparam logic [2:0] KIND_WB = 3'd3;
	localparam logic [2:0] KIND_WH = 3'd4;
	localparam logic [2:0] KIND_WW = 3'd5;

	// Targets.
	localparam logic [3:0] TGT_RAM     = 4'd0;
	localparam logic [3:0] TGT_SCRATCH = 4'd1;
	localparam logic [3:0] TGT_SERIAL  = 4'd2;
	localparam logic [3:0] TGT_DMA     = 4'd3;
	localparam logic [3:0] TGT_CDROM   = 4'd4;
	localparam logic [3:0] TGT_BIOS    = 4'd5;
	localparam logic [3:0] TGT_ISTAT   = 4'd6;
	localparam logic [3:0] TGT_IMASK   = 4'd7;
	localparam logic [3:0] TGT_SPU     = 4'd8;
	localparam logic [3:0] TGT_TIMERS  = 4'd9;
	localparam logic [3:0] TGT_GPU0    = 4'd10;
	localparam logic [3:0] TGT_GPU1    = 4'd11;
	localparam logic [3:0] TGT_MDEC0   = 4'd12;
	localparam logic [3:0] TGT_MDEC1   = 4'd13;
	localparam logic [3:0] TGT_CONST   = 4'd14;
	localparam logic [3:0] TGT_IGNORE  = 4'd15;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNALIGNED = 2'd1;
	localparam logic [1:0] ST_UNMAPPED  = 2'd2;

	// Segment handling.
	localparam logic [2:0]  SEG_K0     = 3'b100;
	localparam logic [2:0]  SEG_K1     = 3'b101;
	localparam logic [31:0] SEG_K0_MSK = 32'h7fffffff;
	localparam logic [31:0] SEG_K1_MSK = 32'h1fffffff;

	// Memory map.
	localparam logic [31:0] RAM_WINDOW   = 32'h0080_0000;
	localparam logic [31:0] EXP1_BASE    = 32'h1F00_0000;
	localparam logic [31:0] EXP1_LEN     = 32'h0008_0000;
	localparam logic [31:0] SCRATCH_BASE = 32'h1F80_0000;
	localparam logic [31:0] MC1_BASE     = 32'h1F80_1000;
	localparam logic [31:0] MC1_LEN      = 32'd36;
	localparam logic [31:0] SIO_BASE     = 32'h1F80_1040;
	localparam logic [31:0] SIO_LEN      = 32'h20;
	localparam logic [31:0] RAM_SIZE_REG = 32'h1F80_1060;
	localparam logic [31:0] ISTAT_REG    = 32'h1F80_1070;
	localparam logic [31:0] IMASK_REG    = 32'h1F80_1074;
	localparam logic [31:0] DMA_BASE     = 32'h1F80_1080;
	localparam logic [31:0] DMA_LEN      = 32'h80;
	localparam logic [31:0] TMR_BASE     = 32'h1F80_1100;
	localparam logic [31:0] TMR_LEN      = 32'h30;
	localparam logic [31:0] CD_BASE      = 32'h1F80_1800;
	localparam logic [31:0] CD_LEN       = 32'd4;
	localparam logic [31:0] GPU0_REG     = 32'h1F80_1810;
	localparam logic [31:0] GPU1_REG     = 32'h1F80_1814;
	localparam logic [31:0] MDEC0_REG    = 32'h1F80_1820;
	localparam logic [31:0] MDEC1_REG    = 32'h1F80_1824;
	localparam logic [31:0] SPU_BASE     = 32'h1F80_1C00;
	localparam logic [31:0] SPU_LEN      = 32'h400;
	localparam logic [31:0] EXP2_BASE    = 32'h1F80_2000;
	localparam logic [31:0] EXP2_LEN     = 32'h2000;
	localparam logic [31:0] BIOS_BASE    = 32'h1FC0_0000;
	localparam logic [31:0] CACHE_CTRL   = 32'hFFFE_0130;

	localparam logic [31:0] EXP1_RDATA    = 32'h0000_00FF;
	localparam logic [31:0] RAM_SIZE_DATA = 32'h0000_0B88;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] addr;
		logic [31:0] wdata;
	} access_t;

	typedef struct packed {
		logic [3:0]          target;
		logic [OFFSET_W-1:0] offset;
		logic [31:0]         cdata;
		logic                keep;
		logic [31:0]         wdata;
		logic [1:0]          status;
	} result_t;

	function automatic logic in_rng(logic [31:0] a, logic [31:0] base, logic [31:0] len);
		return (a >= base) && ((a - base) < len);
	endfunction

	function automatic result_t mk_hit(logic [3:0] tgt, logic [OFFSET_W-1:0] off);
		result_t r;
		r = '0;
		r.target = tgt;
		r.offset = off;
		r.status = ST_OK;
		return r;
	endfunction

	function automatic result_t mk_const(logic [31:0] v);
		result_t r;
		r = '0;
		r.target = TGT_CONST;
		r.cdata  = v;
		r.status = ST_OK;
		return r;
	endfunction

endpackage

// ===== hw/rtl/busdec_decode.sv =====
// Combinational decode of one bus beat: segment strip, map match, write data masking.
// Depends on busdec_pkg.
`timescale 1ns / 1ps

module busdec_decode #(
	parameter int unsigned RAM_BYTES     = busdec_pkg::RAM_BYTES_DEF,
	parameter int unsigned BIOS_BYTES    = busdec_pkg::BIOS_BYTES_DEF,
	parameter int unsigned SCRATCH_BYTES = busdec_pkg::SCRATCH_BYTES_DEF
) (
	input  busdec_pkg::access_t acc,
	output busdec_pkg::result_t res
);

	localparam logic [31:0] RAM_MASK = 32'(RAM_BYTES - 1);
	localparam logic [31:0] BIOS_LEN = 32'(BIOS_BYTES);
	localparam logic [31:0] SCR_LEN  = 32'(SCRATCH_BYTES);
	localparam int OW = busdec_pkg::OFFSET_W;

	logic [31:0] pa;
	logic        is_half, is_word, is_write, unaligned;

	logic hit_ram, hit_scr, hit_exp1, hit_mc1, hit_sio, hit_ramsz, hit_istat, hit_imask;
	logic hit_dma, hit_tmr, hit_tmr_end, hit_cd, hit_gpu0, hit_gpu1, hit_mdec0, hit_mdec1;
	logic hit_spu, hit_exp2, hit_bios, hit_cache;

	logic [31:0] d_scr, d_sio, d_dma, d_tmr, d_cd, d_spu, d_bios, ram_off;
	logic [OW-1:0] off_tmr, off_dma_w;

	busdec_pkg::result_t d;

	always_comb begin
		unique case (acc.addr[31:29])
			busdec_pkg::SEG_K0: pa = acc.addr & busdec_pkg::SEG_K0_MSK;
			busdec_pkg::SEG_K1: pa = acc.addr & busdec_pkg::SEG_K1_MSK;
			default:            pa = acc.addr;
		endcase
	end

	assign is_half  = (acc.kind == busdec_pkg::KIND_RH) || (acc.kind == busdec_pkg::KIND_WH);
	assign is_word  = (acc.kind == busdec_pkg::KIND_RW) || (acc.kind == busdec_pkg::KIND_WW);
	assign is_write = (acc.kind == busdec_pkg::KIND_WB) || (acc.kind == busdec_pkg::KIND_WH)
		|| (acc.kind == busdec_pkg::KIND_WW);
	assign unaligned = (is_half && acc.addr[0]) || (is_word && (acc.addr[1:0] != 2'b00));

	// Region matches, all evaluated in parallel on the physical address.
	assign hit_ram     = pa < busdec_pkg::RAM_WINDOW;
	assign hit_scr     = busdec_pkg::in_rng(pa, busdec_pkg::SCRATCH_BASE, SCR_LEN);
	assign hit_exp1    = busdec_pkg::in_rng(pa, busdec_pkg::EXP1_BASE, busdec_pkg::EXP1_LEN);
	assign hit_mc1     = busdec_pkg::in_rng(pa, busdec_pkg::MC1_BASE, busdec_pkg::MC1_LEN);
	assign hit_sio     = busdec_pkg::in_rng(pa, busdec_pkg::SIO_BASE, busdec_pkg::SIO_LEN);
	assign hit_ramsz   = pa == busdec_pkg::RAM_SIZE_REG;
	assign hit_istat   = pa == busdec_pkg::ISTAT_REG;
	assign hit_imask   = pa == busdec_pkg::IMASK_REG;
	assign hit_dma     = busdec_pkg::in_rng(pa, busdec_pkg::DMA_BASE, busdec_pkg::DMA_LEN);
	assign hit_tmr     = busdec_pkg::in_rng(pa, busdec_pkg::TMR_BASE, busdec_pkg::TMR_LEN);
	assign hit_tmr_end = pa == (busdec_pkg::TMR_BASE + busdec_pkg::TMR_LEN);
	assign hit_cd      = busdec_pkg::in_rng(pa, busdec_pkg::CD_BASE, busdec_pkg::CD_LEN);
	assign hit_gpu0    = pa == busdec_pkg::GPU0_REG;
	assign hit_gpu1    = pa == busdec_pkg::GPU1_REG;
	assign hit_mdec0   = pa == busdec_pkg::MDEC0_REG;
	assign hit_mdec1   = pa == busdec_pkg::MDEC1_REG;
	assign hit_spu     = busdec_pkg::in_rng(pa, busdec_pkg::SPU_BASE, busdec_pkg::SPU_LEN);
	assign hit_exp2    = busdec_pkg::in_rng(pa, busdec_pkg::EXP2_BASE, busdec_pkg::EXP2_LEN);
	assign hit_bios    = busdec_pkg::in_rng(pa, busdec_pkg::BIOS_BASE, BIOS_LEN);
	assign hit_cache   = pa == busdec_pkg::CACHE_CTRL;

	assign ram_off = pa & RAM_MASK;
	assign d_scr   = pa - busdec_pkg::SCRATCH_BASE;
	assign d_sio   = pa - busdec_pkg::SIO_BASE;
	assign d_dma   = pa - busdec_pkg::DMA_BASE;
	assign d_tmr   = pa - busdec_pkg::TMR_BASE;
	assign d_cd    = pa - busdec_pkg::CD_BASE;
	assign d_spu   = pa - busdec_pkg::SPU_BASE;
	assign d_bios  = pa - busdec_pkg::BIOS_BASE;

	// Word-indexed devices drop the two byte-lane bits.
	assign off_tmr   = d_tmr[OW+1:2];
	assign off_dma_w = d_dma[OW+1:2];

	always_comb begin
		d = '0;
		d.status = busdec_pkg::ST_UNMAPPED;
		if (!unaligned) begin
			unique case (acc.kind)
				busdec_pkg::KIND_RB: begin
					priority if (hit_ram) d = busdec_pkg::mk_hit(busdec_pkg::TGT_RAM, ram_off[OW-1:0]);
					else if (hit_scr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SCRATCH, d_scr[OW-1:0]);
					else if (hit_exp1) d = busdec_pkg::mk_const(busdec_pkg::EXP1_RDATA);
					else if (hit_sio) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SERIAL, d_sio[OW-1:0]);
					else if (hit_dma) d = busdec_pkg::mk_hit(busdec_pkg::TGT_DMA, d_dma[OW-1:0]);
					else if (hit_cd) d = busdec_pkg::mk_hit(busdec_pkg::TGT_CDROM, d_cd[OW-1:0]);
					else if (hit_bios) d = busdec_pkg::mk_hit(busdec_pkg::TGT_BIOS, d_bios[OW-1:0]);
					else d.status = busdec_pkg::ST_UNMAPPED;
				end
				busdec_pkg::KIND_RH: begin
					priority if (hit_ram) d = busdec_pkg::mk_hit(busdec_pkg::TGT_RAM, ram_off[OW-1:0]);
					else if (hit_scr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SCRATCH, d_scr[OW-1:0]);
					else if (hit_sio) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SERIAL, d_sio[OW-1:0]);
					else if (hit_istat) d = busdec_pkg::mk_hit(busdec_pkg::TGT_ISTAT, '0);
					else if (hit_imask) d = busdec_pkg::mk_hit(busdec_pkg::TGT_IMASK, '0);
					else if (hit_spu) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SPU, d_spu[OW-1:0]);
					else if (hit_tmr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_TIMERS, off_tmr);
					else if (hit_bios) d = busdec_pkg::mk_hit(busdec_pkg::TGT_BIOS, d_bios[OW-1:0]);
					else if (hit_tmr_end) d = busdec_pkg::mk_const('0);
					else d.status = busdec_pkg::ST_UNMAPPED;
				end
				busdec_pkg::KIND_RW: begin
					priority if (hit_ram) d = busdec_pkg::mk_hit(busdec_pkg::TGT_RAM, ram_off[OW-1:0]);
					else if (hit_scr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SCRATCH, d_scr[OW-1:0]);
					else if (hit_mc1) d = busdec_pkg::mk_const('0);
					else if (hit_istat) d = busdec_pkg::mk_hit(busdec_pkg::TGT_ISTAT, '0);
					else if (hit_imask) d = busdec_pkg::mk_hit(busdec_pkg::TGT_IMASK, '0);
					else if (hit_sio) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SERIAL, d_sio[OW-1:0]);
					else if (hit_dma) d = busdec_pkg::mk_hit(busdec_pkg::TGT_DMA, off_dma_w);
					else if (hit_tmr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_TIMERS, off_tmr);
					else if (hit_gpu0) d = busdec_pkg::mk_hit(busdec_pkg::TGT_GPU0, '0);
					else if (hit_gpu1) d = busdec_pkg::mk_hit(busdec_pkg::TGT_GPU1, '0);
					else if (hit_mdec0) d = busdec_pkg::mk_hit(busdec_pkg::TGT_MDEC0, '0);
					else if (hit_mdec1) d = busdec_pkg::mk_hit(busdec_pkg::TGT_MDEC1, '0);
					else if (hit_bios) d = busdec_pkg::mk_hit(busdec_pkg::TGT_BIOS, d_bios[OW-1:0]);
					else if (hit_ramsz) d = busdec_pkg::mk_const(busdec_pkg::RAM_SIZE_DATA);
					else d.status = busdec_pkg::ST_UNMAPPED;
				end
				busdec_pkg::KIND_WB: begin
					priority if (hit_ram) d = busdec_pkg::mk_hit(busdec_pkg::TGT_RAM, ram_off[OW-1:0]);
					else if (hit_scr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SCRATCH, d_scr[OW-1:0]);
					else if (hit_sio) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SERIAL, d_sio[OW-1:0]);
					else if (hit_dma) d = busdec_pkg::mk_hit(busdec_pkg::TGT_DMA, d_dma[OW-1:0]);
					else if (hit_cd) d = busdec_pkg::mk_hit(busdec_pkg::TGT_CDROM, d_cd[OW-1:0]);
					else if (hit_exp2) d = busdec_pkg::mk_hit(busdec_pkg::TGT_IGNORE, '0);
					else d.status = busdec_pkg::ST_UNMAPPED;
				end
				busdec_pkg::KIND_WH: begin
					priority if (hit_ram) d = busdec_pkg::mk_hit(busdec_pkg::TGT_RAM, ram_off[OW-1:0]);
					else if (hit_scr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SCRATCH, d_scr[OW-1:0]);
					else if (hit_sio) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SERIAL, d_sio[OW-1:0]);
					else if (hit_istat) begin
						d = busdec_pkg::mk_hit(busdec_pkg::TGT_ISTAT, '0);
						d.keep = 1'b1;
					end else if (hit_imask) begin
						d = busdec_pkg::mk_hit(busdec_pkg::TGT_IMASK, '0);
						d.keep = 1'b1;
					end else if (hit_tmr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_TIMERS, off_tmr);
					else if (hit_spu) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SPU, d_spu[OW-1:0]);
					else if (hit_exp2) d = busdec_pkg::mk_hit(busdec_pkg::TGT_IGNORE, '0);
					else d.status = busdec_pkg::ST_UNMAPPED;
				end
				busdec_pkg::KIND_WW: begin
					// A word write into expansion 1 stays unmapped.
					priority if (hit_ram) d = busdec_pkg::mk_hit(busdec_pkg::TGT_RAM, ram_off[OW-1:0]);
					else if (hit_exp1) d.status = busdec_pkg::ST_UNMAPPED;
					else if (hit_scr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SCRATCH, d_scr[OW-1:0]);
					else if (hit_mc1 || hit_ramsz || hit_cache)
						d = busdec_pkg::mk_hit(busdec_pkg::TGT_IGNORE, '0);
					else if (hit_istat) d = busdec_pkg::mk_hit(busdec_pkg::TGT_ISTAT, '0);
					else if (hit_imask) d = busdec_pkg::mk_hit(busdec_pkg::TGT_IMASK, '0);
					else if (hit_tmr) d = busdec_pkg::mk_hit(busdec_pkg::TGT_TIMERS, off_tmr);
					else if (hit_dma) d = busdec_pkg::mk_hit(busdec_pkg::TGT_DMA, off_dma_w);
					else if (hit_gpu0) d = busdec_pkg::mk_hit(busdec_pkg::TGT_GPU0, '0);
					else if (hit_gpu1) d = busdec_pkg::mk_hit(busdec_pkg::TGT_GPU1, '0);
					else if (hit_mdec0) d = busdec_pkg::mk_hit(busdec_pkg::TGT_MDEC0, '0);
					else if (hit_mdec1) d = busdec_pkg::mk_hit(busdec_pkg::TGT_MDEC1, '0);
					else if (hit_spu) d = busdec_pkg::mk_hit(busdec_pkg::TGT_SPU, d_spu[OW-1:0]);
					else d.status = busdec_pkg::ST_UNMAPPED;
				end
				default: d.status = busdec_pkg::ST_UNMAPPED;
			endcase
		end else begin
			d.status = busdec_pkg::ST_UNALIGNED;
		end
	end

	// Errors collapse to a bare target; good writes to real devices forward masked data.
	always_comb begin
		res = d;
		res.wdata = '0;
		if (d.status != busdec_pkg::ST_OK) begin
			res = '0;
			res.status = d.status;
			res.target = is_write || (acc.kind > busdec_pkg::KIND_WW) ? busdec_pkg::TGT_IGNORE
				: busdec_pkg::TGT_CONST;
		end else if (is_write && (d.target < busdec_pkg::TGT_CONST)) begin
			priority if (is_word) res.wdata = acc.wdata;
			else if (is_half) res.wdata = {16'h0000, acc.wdata[15:0]};
			else res.wdata = {24'h000000, acc.wdata[7:0]};
		end
	end

endmodule

// ===== hw/rtl/bus_address_decoder_unit.sv =====
// Bus address decoder: one access beat in, one decoded result beat out, every
// cycle. A beat is registered on entry, decoded by compare-and-mask logic in
// busdec_decode, and registered again on exit, so its result is offered on the
// outputs once it has passed the input register and the result register, and a new beat is taken in
// every cycle while the output flows. The input register and the result
// register hold a beat each, so behind a stalled output the input takes one
// more beat and then stalls until the waiting result is taken.
// Depends on busdec_pkg, busdec_decode and bus_address_decoder_unit_defines.svh.
`timescale 1ns / 1ps
`include "bus_address_decoder_unit_defines.svh"

module bus_address_decoder_unit #(
	parameter int unsigned RAM_BYTES     = busdec_pkg::RAM_BYTES_DEF,
	parameter int unsigned BIOS_BYTES    = busdec_pkg::BIOS_BYTES_DEF,
	parameter int unsigned SCRATCH_BYTES = busdec_pkg::SCRATCH_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  access_kind,
	input  logic [31:0] bus_address,
	input  logic [31:0] write_data,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  target,
	output logic [20:0] device_offset,
	output logic [31:0] constant_data,
	output logic        keep_upper_half,
	output logic [31:0] device_write_data,
	output logic [1:0]  access_status
);

	logic                 v_s1, v_s2;
	busdec_pkg::access_t  acc_s1;
	busdec_pkg::result_t  dec, res_s2;
	logic                 adv_s2, load_s1;

	// The result register moves when it is empty or its beat is taken.
	assign adv_s2   = !v_s2 || !out_stall;
	assign load_s1  = !v_s1 || adv_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			acc_s1.kind  <= access_kind;
			acc_s1.addr  <= bus_address;
			acc_s1.wdata <= write_data;
		end
		if (adv_s2 && v_s1) res_s2 <= dec;
	end

	busdec_decode #(
		.RAM_BYTES     (RAM_BYTES),
		.BIOS_BYTES    (BIOS_BYTES),
		.SCRATCH_BYTES (SCRATCH_BYTES)
	) u_decode (
		.acc (acc_s1),
		.res (dec)
	);

	assign out_valid         = v_s2;
	assign target            = res_s2.target;
	assign device_offset     = res_s2.offset;
	assign constant_data     = res_s2.cdata;
	assign keep_upper_half   = res_s2.keep;
	assign device_write_data = res_s2.wdata;
	assign access_status     = res_s2.status;

	`BUSDEC_ASSERT_NOW(a_stall_only_when_full, in_stall, v_s1 && out_valid && out_stall)
	`BUSDEC_ASSERT_NEXT(a_s1_moves_out, v_s1 && !(out_valid && out_stall), out_valid)
	`BUSDEC_ASSERT_NOW(a_error_bare, out_valid && (access_status != busdec_pkg::ST_OK),
		(device_offset == '0) && (device_write_data == '0) && !keep_upper_half)
	`BUSDEC_ASSERT_NOW(a_keep_irq_only, out_valid && keep_upper_half,
		(target == busdec_pkg::TGT_ISTAT) || (target == busdec_pkg::TGT_IMASK))

endmodule
